[sv/audio_frame_peak_rms_envelope_assert.svh]
// Assertion macros shared by the level meter RTL.
`ifndef AUDIO_FRAME_PEAK_RMS_ENVELOPE_ASSERT_SVH
`define AUDIO_FRAME_PEAK_RMS_ENVELOPE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define AFPRE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define AFPRE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/afpre_pkg.sv]
// Types, constants and helpers of the audio level meter.
package afpre_pkg;

	localparam int NUM_BUCKETS_DEF = 16;
	localparam int MAX_SAMPLES_DEF = 2048;
	localparam int SPF_W           = 12;
	localparam logic [SPF_W-1:0] SPF_RESET = 12'd736;
	localparam int LEVEL_SHIFT     = 7;
	localparam logic [7:0] LEVEL_MAX = 8'd255;
	// mean square of a magnitude of at most 32768 fits in 31 bits
	localparam int QW              = 31;

	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_END    = 1'b1;

	typedef struct packed {
		logic               mode;
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
		logic        [31:0] frame_index;
	} in_word_t;

	typedef struct packed {
		logic [31:0] out_frame;
		logic [3:0]  bucket_index;
		logic [7:0]  peak_level;
		logic [7:0]  rms_level;
		logic        last_bucket;
	} out_word_t;

	function automatic logic [7:0] level8(input logic [15:0] v);
		logic [15:0] s;
		s = v >> LEVEL_SHIFT;
		return (s > 16'(LEVEL_MAX)) ? LEVEL_MAX : s[7:0];
	endfunction

endpackage

[sv/audio_frame_peak_rms_envelope.sv]
// Bucketed peak and RMS level meter over frames of stereo audio.
// Sample word: accept, BW bucket search steps, a memory read, a write back
//   (BW = clog2(NUM_BUCKETS)); one word at a time.
// Frame end word: per bucket a read, a load, SUM_W divide steps, 16 root
//   steps and an output load, which waits until the output register frees.
// Reset (arst_n low) clears frame, counts and bucket valid bits at once;
//   the frame length register returns to 736. No clearing pass is needed.
`include "audio_frame_peak_rms_envelope_assert.svh"

module audio_frame_peak_rms_envelope import afpre_pkg::*; #(
	parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_stall,
	input  in_word_t         sample_word,
	output logic             result_valid,
	input  logic             result_stall,
	output out_word_t        result_word,
	input  logic             cfg_we,
	input  logic [SPF_W-1:0] cfg_wdata
);

	// widths follow the parameters
	localparam int BW     = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int SB_W   = (BW > 1) ? $clog2(BW) : 1;
	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W  = 31 + CNT_W;
	localparam int DC_W   = $clog2(SUM_W);
	localparam int PROD_W = CNT_W + SPF_W + 7;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_SRCH  = 8'b0000_0010,
		ST_READ  = 8'b0000_0100,
		ST_UPD   = 8'b0000_1000,
		ST_EREAD = 8'b0001_0000,
		ST_ELOAD = 8'b0010_0000,
		ST_EDIV  = 8'b0100_0000,
		ST_ESQRT = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic [15:0]      peak;
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] cnt;
	} entry_t;

	// bucket store: one synchronous memory, valid bits stand in for clearing
	entry_t mem [NUM_BUCKETS];
	entry_t rd_entry_q;
	logic   rd_vld_q;
	logic [NUM_BUCKETS-1:0] vld_q;

	state_t           st_q;
	logic             eout_q;     // waiting to load the output register
	logic [SPF_W-1:0] spf_q;
	logic [31:0]      cur_q;
	logic [CNT_W-1:0] n_q;
	logic [15:0]      a_q;        // mono magnitude of the word in work
	logic [31:0]      sq_q;       // its square
	logic [BW-1:0]    b_q;        // target bucket
	logic [SB_W-1:0]  sbit_q;     // bucket search bit
	logic [BW-1:0]    k_q;        // bucket being reported

	// divide and root unit
	logic [CNT_W-1:0] dvs_q;
	logic [CNT_W-1:0] rem_q;
	logic [SUM_W-1:0] quo_q;
	logic [DC_W-1:0]  dcnt_q;
	logic [QW-1:0]    x_q;
	logic [QW-1:0]    root_q;
	logic [QW-1:0]    sb_q;
	logic [15:0]      pk_q;

	out_word_t res_q;
	logic      res_valid_q;

	logic            accept;
	logic            frame_hit;
	logic [16:0]     sum_lr;
	logic [16:0]     mono;
	logic [16:0]     mag;
	logic [BW-1:0]   rd_addr;
	logic [BW-1:0]   trial;
	logic [PROD_W-1:0] nnb;
	logic [PROD_W-1:0] tprod;
	logic            trial_ok;
	entry_t          cur_entry;
	entry_t          wr_entry;
	logic [CNT_W:0]  dshift;
	logic            dge;
	logic [QW-1:0]   tsum;
	logic            out_free;
	logic            last_k;
	logic            load_out;

	assign accept       = sample_valid && !sample_stall;
	assign sample_stall = (st_q != ST_IDLE) || eout_q;
	assign frame_hit    = (sample_word.frame_index == cur_q);
	assign result_valid = res_valid_q;
	assign result_word  = res_q;

	// mono mix: average truncated toward zero, then magnitude
	always_comb begin
		sum_lr = {sample_word.left_sample[15], sample_word.left_sample}
			+ {sample_word.right_sample[15], sample_word.right_sample};
		mono   = $signed(sum_lr + {16'd0, sum_lr[16]}) >>> 1;
		mag    = mono[16] ? (17'd0 - mono) : mono;
	end

	// bucket search: largest b below NUM_BUCKETS with b*spf <= n*NUM_BUCKETS
	assign trial    = b_q | (BW'(1) << sbit_q);
	assign nnb      = PROD_W'(n_q) * PROD_W'(NUM_BUCKETS);
	assign tprod    = PROD_W'(trial) * PROD_W'(spf_q);
	assign trial_ok = (trial <= BW'(NUM_BUCKETS - 1)) && (tprod <= nnb);

	assign rd_addr   = (st_q == ST_READ) ? b_q : k_q;
	assign cur_entry = rd_vld_q ? rd_entry_q : '0;

	always_comb begin
		wr_entry      = cur_entry;
		wr_entry.peak = (a_q > cur_entry.peak) ? a_q : cur_entry.peak;
		wr_entry.sum  = cur_entry.sum + SUM_W'(sq_q);
		wr_entry.cnt  = cur_entry.cnt + CNT_W'(1);
	end

	// one restoring divide step, one root step
	assign dshift = {rem_q, quo_q[SUM_W-1]};
	assign dge    = (dshift >= {1'b0, dvs_q});
	assign tsum   = root_q + sb_q;

	assign out_free = !res_valid_q || !result_stall;
	assign last_k   = (k_q == BW'(NUM_BUCKETS - 1));
	assign load_out = eout_q && out_free;

	// bucket memory: write back in the update state, registered read
	always_ff @(posedge clk) begin
		if (st_q == ST_UPD) begin
			mem[b_q] <= wr_entry;
		end
		rd_entry_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spf_q <= SPF_RESET;
		end else if (cfg_we) begin
			spf_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			eout_q   <= 1'b0;
			cur_q    <= '0;
			n_q      <= '0;
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
			k_q      <= '0;
		end else begin
			rd_vld_q <= vld_q[rd_addr];
			unique case (st_q)
				ST_IDLE: begin
					if (load_out) begin
						eout_q <= 1'b0;
						if (last_k) begin
							// frame reported: clear and advance
							vld_q <= '0;
							n_q   <= '0;
							cur_q <= cur_q + 32'd1;
						end else begin
							k_q  <= k_q + BW'(1);
							st_q <= ST_EREAD;
						end
					end else if (accept) begin
						if (sample_word.mode == MODE_SAMPLE) begin
							if (!frame_hit) begin
								vld_q <= '0;
								n_q   <= '0;
								cur_q <= sample_word.frame_index;
							end
							// drop words beyond the cap
							if ((frame_hit ? n_q : '0) < CNT_W'(MAX_SAMPLES)) begin
								st_q <= ST_SRCH;
							end
						end else if (!frame_hit) begin
							vld_q <= '0;
							n_q   <= '0;
							cur_q <= sample_word.frame_index + 32'd1;
						end else if (n_q != '0) begin
							k_q  <= '0;
							st_q <= ST_EREAD;
						end
					end
				end
				ST_SRCH: begin
					if (sbit_q == '0) begin
						st_q <= ST_READ;
					end
				end
				ST_READ: st_q <= ST_UPD;
				ST_UPD: begin
					vld_q[b_q] <= 1'b1;
					n_q        <= n_q + CNT_W'(1);
					st_q       <= ST_IDLE;
				end
				ST_EREAD: st_q <= ST_ELOAD;
				ST_ELOAD: st_q <= ST_EDIV;
				ST_EDIV: begin
					if (dcnt_q == '0) begin
						st_q <= ST_ESQRT;
					end
				end
				ST_ESQRT: begin
					// hold in idle with the result pending until the output register frees
					if (sb_q[0]) begin
						st_q   <= ST_IDLE;
						eout_q <= 1'b1;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			a_q    <= mag[15:0];
			b_q    <= '0;
			sbit_q <= SB_W'(BW - 1);
		end
		if (st_q == ST_SRCH) begin
			sq_q <= 32'(a_q) * 32'(a_q);
			if (trial_ok) begin
				b_q <= trial;
			end
			sbit_q <= sbit_q - SB_W'(1);
		end
		if (st_q == ST_ELOAD) begin
			// empty bucket divides 0 by 1
			pk_q   <= cur_entry.peak;
			rem_q  <= '0;
			dcnt_q <= DC_W'(SUM_W - 1);
			if (cur_entry.cnt == '0) begin
				quo_q <= '0;
				dvs_q <= CNT_W'(1);
			end else begin
				quo_q <= cur_entry.sum;
				dvs_q <= cur_entry.cnt;
			end
		end
		if (st_q == ST_EDIV) begin
			rem_q  <= dge ? CNT_W'(dshift - {1'b0, dvs_q}) : dshift[CNT_W-1:0];
			quo_q  <= {quo_q[SUM_W-2:0], dge};
			dcnt_q <= dcnt_q - DC_W'(1);
			if (dcnt_q == '0) begin
				root_q <= '0;
				sb_q   <= QW'(1) << (QW - 1);
			end
		end
		if (st_q == ST_EDIV && dcnt_q == '0) begin
			x_q <= {quo_q[QW-2:0], dge};
		end
		if (st_q == ST_ESQRT) begin
			if (x_q >= tsum) begin
				x_q    <= x_q - tsum;
				root_q <= (root_q >> 1) + sb_q;
			end else begin
				root_q <= root_q >> 1;
			end
			sb_q <= sb_q >> 2;
		end
	end

	// output register parts the result side from the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_out) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_q.out_frame    <= cur_q;
			res_q.bucket_index <= 4'(k_q);
			res_q.peak_level   <= level8(pk_q);
			res_q.rms_level    <= level8(root_q[15:0]);
			res_q.last_bucket  <= last_k;
		end
	end

	`AFPRE_ASSERT_NOW(a_cap, 1'b1, n_q <= CNT_W'(MAX_SAMPLES), "sample count beyond cap")
	`AFPRE_ASSERT_NEXT(a_clear, load_out && last_k, (n_q == '0) && (vld_q == '0), "no frame clear")
	`AFPRE_ASSERT_NOW(a_rd_latency, st_q == ST_UPD, $past(st_q) == ST_READ, "no prior read")
	`AFPRE_ASSERT_NOW(a_hold_out, eout_q, sample_stall, "word taken during report")

endmodule

[dv/audio_frame_peak_rms_envelope_tb.sv]
// Self-checking testbench for the bucketed peak and RMS audio level meter.
`timescale 1ns / 100ps

module audio_frame_peak_rms_envelope_tb import afpre_pkg::*; ();

	localparam int BUCKETS      = 16;
	localparam int SAMPLE_CAP   = 2048;
	// a frame end runs a divide and a root for every bucket
	localparam int SETTLE_CYCLES = 1200;
	// longest quiet spell: receiver hold-off plus a full frame end, several times over
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES    = 3000;
	localparam int MAX_REPORTS    = 10;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             sample_valid = 1'b0;
	logic             sample_stall;
	in_word_t         sample_word = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	out_word_t        result_word;
	logic             cfg_we = 1'b0;
	logic [SPF_W-1:0] cfg_wdata = '0;

	// shadow of the block's state
	logic [SPF_W-1:0] meter_spf;
	logic [31:0]      meter_frame;
	int unsigned      meter_count;
	int unsigned      meter_peak[BUCKETS];
	longint unsigned  meter_sqsum[BUCKETS];
	int unsigned      meter_bcount[BUCKETS];

	out_word_t  envelope_q[$];
	int         mismatches = 0;
	bit         idle_on = 1'b1;
	bit         hold_req = 1'b0;
	int         hold_cnt = 0;
	int         quiet_cycles = 0;

	audio_frame_peak_rms_envelope DUT (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample_word(sample_word),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_word(result_word),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Wipe the shadow accumulators and move to a new frame.
	function automatic void clear_meter(input logic [31:0] frame);
		meter_frame = frame;
		meter_count = 0;
		for (int k = 0; k < BUCKETS; k++) begin
			meter_peak[k] = 0;
			meter_sqsum[k] = 0;
			meter_bcount[k] = 0;
		end
	endfunction

	// Integer square root, digit by digit, four-to-one.
	function automatic longint unsigned root_floor(input longint unsigned x);
		longint unsigned root;
		longint unsigned bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv >>= 2;
		while (bitv != 0) begin
			if (x >= root + bitv) begin
				x -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic logic [7:0] sat_level(input longint unsigned v);
		longint unsigned s;
		s = v >> 7;
		return (s > 255) ? 8'd255 : s[7:0];
	endfunction

	// Fold one accepted word into the shadow state; queue any envelope words.
	function automatic void predict_envelope(input in_word_t w);
		int          l;
		int          r;
		int          m;
		int unsigned a;
		int unsigned b;
		out_word_t   o;
		if (w.mode == MODE_SAMPLE) begin
			if (w.frame_index != meter_frame)
				clear_meter(w.frame_index);
			if (meter_count >= SAMPLE_CAP)
				return;
			if (meter_spf == 0) begin
				b = BUCKETS - 1;
			end else begin
				b = (meter_count * BUCKETS) / meter_spf;
				if (b > BUCKETS - 1)
					b = BUCKETS - 1;
			end
			l = w.left_sample;
			r = w.right_sample;
			m = (l + r) / 2;
			a = (m < 0) ? -m : m;
			if (a > meter_peak[b])
				meter_peak[b] = a;
			meter_sqsum[b] += longint'(a) * longint'(a);
			meter_bcount[b]++;
			meter_count++;
			return;
		end
		if (w.frame_index != meter_frame) begin
			clear_meter(w.frame_index + 32'd1);
			return;
		end
		if (meter_count == 0)
			return;
		for (int k = 0; k < BUCKETS; k++) begin
			o.out_frame = meter_frame;
			o.bucket_index = k[3:0];
			o.peak_level = sat_level(meter_peak[k]);
			o.rms_level = (meter_bcount[k] == 0) ? 8'd0 :
				sat_level(root_floor(meter_sqsum[k] / meter_bcount[k]));
			o.last_bucket = (k == BUCKETS - 1);
			envelope_q.push_back(o);
		end
		clear_meter(meter_frame + 32'd1);
	endfunction

	// Receiver: check each accepted word, then pick the next stall.
	always @(posedge clk) begin
		if (result_valid && !result_stall) begin
			if (envelope_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected envelope word %p", result_word);
			end else begin
				if (result_word !== envelope_q[0]) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("envelope mismatch: expected %p, got %p",
							envelope_q[0], result_word);
				end
				void'(envelope_q.pop_front());
			end
		end
		if (hold_req) begin
			hold_req = 1'b0;
			hold_cnt = HOLD_CYCLES;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= idle_on && ($urandom_range(99) < 34);
		end
	end

	// Watchdog: end the run if neither side moves a word for too long.
	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Offer one word, with random gaps ahead of it; returns once accepted.
	// Valid stays high so back-to-back words never toggle it within a step.
	task automatic send_word(input in_word_t w);
		while (idle_on && ($urandom_range(99) < 34)) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_word <= w;
		do
			@(posedge clk);
		while (sample_stall);
		predict_envelope(w);
	endtask

	task automatic send_sample(input logic [31:0] frame, input logic [15:0] l,
		input logic [15:0] r);
		in_word_t w;
		w.mode = MODE_SAMPLE;
		w.left_sample = l;
		w.right_sample = r;
		w.frame_index = frame;
		send_word(w);
	endtask

	task automatic send_end(input logic [31:0] frame);
		in_word_t w;
		w.mode = MODE_END;
		w.left_sample = 16'($urandom);
		w.right_sample = 16'($urandom);
		w.frame_index = frame;
		send_word(w);
	endtask

	// Drop valid, wait for every envelope word, then let a frame end finish.
	task automatic drain_block();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (envelope_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_spf(input logic [SPF_W-1:0] v);
		drain_block();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		meter_spf = v;
	endtask

	// Random samples for one frame, closed by a matching frame end.
	task automatic send_frame(input logic [31:0] frame, input int n);
		for (int i = 0; i < n; i++)
			send_sample(frame, 16'($urandom), 16'($urandom));
		send_end(frame);
	endtask

	// Extremes of the fields, rounding toward zero, empty and mismatched ends.
	task automatic test_directed();
		send_sample(32'd0, 16'h7FFF, 16'h7FFF);
		send_sample(32'd0, 16'h8000, 16'h8000);
		send_sample(32'd0, 16'h8000, 16'h7FFF);
		send_sample(32'd0, 16'hFFFF, 16'h0000);
		send_sample(32'd0, 16'h0001, 16'h0000);
		send_sample(32'd0, 16'h0000, 16'h0000);
		send_sample(32'd0, 16'h7FFF, 16'h8000);
		send_end(32'd0);
		// empty frame 1 ends with nothing
		send_end(32'd1);
		// mismatched end clears and skips ahead
		send_sample(32'd5, 16'h4000, 16'hC000);
		send_end(32'd77);
		send_sample(32'd78, 16'h1234, 16'h8765);
		// frame change on a sample drops the old buckets
		send_sample(32'd90, 16'h7FFF, 16'h7FFF);
		send_sample(32'd90, 16'h0100, 16'h0100);
		send_end(32'd90);
		// frame number wraps after the last value
		send_sample(32'hFFFF_FFFF, 16'h8001, 16'h8001);
		send_sample(32'hFFFF_FFFF, 16'h5555, 16'hAAAA);
		send_end(32'hFFFF_FFFF);
		send_sample(32'd0, 16'h0FFF, 16'hF001);
		send_end(32'd0);
		send_end(32'hFFFF_FFFE);
	endtask

	// Walk the register through its extremes and a few ordinary values.
	task automatic test_spf_settings();
		logic [SPF_W-1:0] spf_list[6] = '{12'd0, 12'd1, 12'd4095, 12'd2048, 12'd17, 12'd736};
		foreach (spf_list[i]) begin
			write_spf(spf_list[i]);
			send_frame(32'd1000 + i, 12 + $urandom_range(8));
		end
	endtask

	// Mostly well-formed frames with random content, some noise, one calm stretch.
	task automatic test_random_frames();
		logic [31:0] frame;
		int          items;
		int          pick;
		frame = $urandom;
		items = 0;
		while (items < 180) begin
			idle_on = !(items >= 70 && items < 110);
			pick = $urandom_range(99);
			if (pick < 70) begin
				pick = $urandom_range(1, 24);
				send_frame(frame, pick);
				items += pick + 1;
				frame = frame + 32'd1;
			end else if (pick < 80) begin
				send_end(frame ^ (32'd1 << $urandom_range(31)));
				frame = $urandom;
				items++;
			end else if (pick < 90) begin
				send_sample(frame, 16'($urandom), 16'($urandom));
				frame = $urandom;
				items++;
			end else begin
				send_end(frame);
				items++;
			end
		end
		idle_on = 1'b1;
		drain_block();
	endtask

	// Hold the receiver off while frames keep coming so the input backs up.
	task automatic test_backpressure();
		write_spf(12'd40);
		hold_req = 1'b1;
		for (int f = 0; f < 4; f++)
			send_frame(32'd5000 + f, 8);
		drain_block();
		send_frame(32'd6000, 5);
	endtask

	initial begin
		meter_spf = SPF_RESET;
		clear_meter(32'd0);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_spf_settings();
		test_random_frames();
		test_backpressure();

		drain_block();
		if (envelope_q.size() != 0)
			mismatches++;
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+sv
sv/afpre_pkg.sv
sv/audio_frame_peak_rms_envelope.sv
dv/audio_frame_peak_rms_envelope_tb.sv
